/* src/tts_pkg.sv */
// Shared types, constants and the tetrahedron corner table for the hexahedron splitter.
// No dependencies; imported by every module of the block.
`default_nettype none
package tts_pkg;

	localparam int CELL_W         = 24;
	localparam int DIM_W          = 12;
	localparam int NUM_CORNERS    = 8;
	localparam int NUM_TETS       = 6;
	localparam int TET_CNT_W      = 3;
	localparam int INDEX_BITS_DEF = 24;
	localparam int BITS_PER_STAGE = 4;
	localparam int DIV_STAGES     = CELL_W / BITS_PER_STAGE;
	localparam int ADDR_W         = 4;
	localparam logic [TET_CNT_W-1:0] LAST_TET = TET_CNT_W'(NUM_TETS - 1);

	typedef enum logic [1:0] {
		REG_MIRROR = 2'd0,
		REG_CELLS_X = 2'd1,
		REG_CELLS_Y = 2'd2,
		REG_NONE = 2'd3
	} reg_idx_t;

	// corner positions of the six tetrahedra, first vertex ordering
	localparam logic [2:0] TET_TBL [NUM_TETS][4] = '{
		'{3'd0, 3'd5, 3'd1, 3'd6},
		'{3'd0, 3'd1, 3'd3, 3'd6},
		'{3'd1, 3'd3, 3'd6, 3'd2},
		'{3'd6, 3'd3, 3'd0, 3'd7},
		'{3'd6, 3'd7, 3'd0, 3'd5},
		'{3'd7, 3'd5, 3'd4, 3'd0}
	};

	// control word of one divider stage
	typedef struct packed {
		logic [CELL_W-1:0] cidx;
		logic [CELL_W-1:0] num;    // dividend shifting out, quotient shifting in
		logic [DIM_W-1:0]  rem;
		logic              r1_odd; // remainder of the X division is odd
	} div_ctl_t;

endpackage
`default_nettype wire

/* src/tts_div_stage.sv */
// One stage of the pipelined restoring divider: four quotient bits per stage.
// Carries the corner indices alongside; depends on tts_pkg.
`default_nettype none
module tts_div_stage
	import tts_pkg::*;
#(
	parameter int CORNER_W = INDEX_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [DIM_W-1:0]                divisor,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire div_ctl_t                        in_ctl,
	input  wire logic [NUM_CORNERS*CORNER_W-1:0] in_corn,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output div_ctl_t                             out_ctl,
	output logic [NUM_CORNERS*CORNER_W-1:0]      out_corn
);

	logic                            valid_s1;
	div_ctl_t                        ctl_s1;
	logic [NUM_CORNERS*CORNER_W-1:0] corn_s1;
	div_ctl_t                        nxt;

	always_comb begin
		logic [DIM_W:0] r13;
		nxt = in_ctl;
		for (int b = 0; b < BITS_PER_STAGE; b++) begin
			r13 = {nxt.rem, nxt.num[CELL_W-1]};
			nxt.num = {nxt.num[CELL_W-2:0], 1'b0};
			if (r13 >= {1'b0, divisor}) begin
				r13 = r13 - {1'b0, divisor};
				nxt.num[0] = 1'b1;
			end
			nxt.rem = r13[DIM_W-1:0];
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ctl_s1  <= nxt;
			corn_s1 <= in_corn;
		end
	end

	assign out_valid = valid_s1;
	assign out_ctl   = ctl_s1;
	assign out_corn  = corn_s1;

endmodule
`default_nettype wire

/* src/tts_emit.sv */
// Mirrors the corners of one cell and issues its six tetrahedra through an output register.
// Depends on tts_pkg.
`default_nettype none
module tts_emit
	import tts_pkg::*;
#(
	parameter int CORNER_W = INDEX_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            mirror_en,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire div_ctl_t                        in_ctl,
	input  wire logic [NUM_CORNERS*CORNER_W-1:0] in_corn,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [5*CELL_W-1:0]                  out_data,
	output logic                                 out_last
);

	logic                 busy_q;
	logic [TET_CNT_W-1:0] cnt_q;
	logic                 flip_q;
	logic [CELL_W-1:0]    cell_q;
	logic [CORNER_W-1:0]  corn_q [NUM_CORNERS];
	logic                 oval_q;
	logic [5*CELL_W-1:0]  odata_q;
	logic                 olast_q;

	logic                mx, my, mz, adv, load;
	logic [CORNER_W-1:0] c0 [NUM_CORNERS];
	logic [CORNER_W-1:0] c1 [NUM_CORNERS];
	logic [CORNER_W-1:0] c2 [NUM_CORNERS];
	logic [CORNER_W-1:0] c3 [NUM_CORNERS];
	logic [CORNER_W-1:0] va, vb, vc, vd;

	// mirror flags from the parities left by the divider
	assign mx = mirror_en && !in_ctl.r1_odd;
	assign my = mirror_en && in_ctl.rem[0];
	assign mz = mirror_en && in_ctl.num[0];

	always_comb begin
		for (int i = 0; i < NUM_CORNERS; i++) begin
			c0[i] = in_corn[i*CORNER_W +: CORNER_W];
		end
		for (int i = 0; i < NUM_CORNERS; i++) begin
			c1[i] = mx ? c0[i ^ 1] : c0[i];
		end
		for (int i = 0; i < NUM_CORNERS; i++) begin
			c2[i] = my ? c1[i ^ 3] : c1[i];
		end
		for (int i = 0; i < NUM_CORNERS; i++) begin
			c3[i] = mz ? c2[i ^ 4] : c2[i];
		end
	end

	always_comb begin
		va = corn_q[0];
		vb = corn_q[0];
		vc = corn_q[0];
		vd = corn_q[0];
		for (int k = 0; k < NUM_TETS; k++) begin
			if (cnt_q == TET_CNT_W'(k)) begin
				va = corn_q[TET_TBL[k][0]];
				vb = corn_q[TET_TBL[k][1]];
				vc = corn_q[TET_TBL[k][2]];
				vd = corn_q[TET_TBL[k][3]];
			end
		end
	end

	assign adv      = busy_q && (!oval_q || out_ready);
	assign in_ready = !busy_q || (adv && cnt_q == LAST_TET);
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			oval_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (adv) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_TET) begin
					busy_q <= 1'b0;
				end
			end
			if (adv) begin
				oval_q <= 1'b1;
			end else if (out_ready) begin
				oval_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			corn_q <= c3;
			flip_q <= mx ^ my ^ mz;
			cell_q <= in_ctl.cidx;
		end
		if (adv) begin
			// odd orientation: exchange the last two vertices
			odata_q <= {cell_q,
				CELL_W'(flip_q ? vc : vd), CELL_W'(flip_q ? vd : vc),
				CELL_W'(vb), CELL_W'(va)};
			olast_q <= (cnt_q == LAST_TET);
		end
	end

	assign out_valid = oval_q;
	assign out_data  = odata_q;
	assign out_last  = olast_q;

endmodule
`default_nettype wire

/* src/hexa_to_six_tetra_split_top.sv */
// Hexahedron to six tetrahedra splitter: input stream, result stream, APB registers.
// Instantiates tts_div_stage and tts_emit; depends on tts_pkg.
//
// Input channel s_*: one transaction per cell, tdata = cell_index, corner0..corner7.
// Output channel m_*: six transactions per cell, tdata = tet_a..tet_d, source_cell;
// m_tlast marks the sixth tetrahedron of a cell.
// Registers over APB: 0x0 mirror_enable, 0x4 cells_x, 0x8 cells_y; pready is tied high.
// Grid parities come from a twelve-stage restoring divider (four quotient bits per
// stage): cell_index / cells_x, then that quotient / cells_y.
// m_tvalid rises once a cell has passed the twelve divider stages and the emitter's
// corner and output registers. The single output channel sets the throughput; while
// the emitter is busy the divider takes a new cell every cycle until its stages fill.
// Reset clears all valid bits and restores the registers (mirroring off, 2 x 1 grid).
// When m_tready is low the output register holds its transaction and the stall backs up
// stage by stage; nothing is dropped or repeated. A zero grid size counts as one.
// Write registers only while no cell is in flight.
`default_nettype none
module hexa_to_six_tetra_split_top
	import tts_pkg::*;
#(
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// cell_index, corner0 .. corner7, 24 bits each from bit 0
	input  wire logic [9*CELL_W-1:0]    s_tdata,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// tet_a, tet_b, tet_c, tet_d, source_cell, 24 bits each from bit 0
	output logic [5*CELL_W-1:0]         m_tdata,
	output logic                        m_tlast,
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [ADDR_W-1:0]      paddr,
	input  wire logic [31:0]            pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int CORNER_W = (INDEX_BITS < CELL_W) ? INDEX_BITS : CELL_W;
	localparam int NST = 2 * DIV_STAGES;

	logic             mirror_q;
	logic [DIM_W-1:0] cells_x_q, cells_y_q, nx, ny;
	reg_idx_t         ridx;

	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_q  <= 1'b0;
			cells_x_q <= DIM_W'(2);
			cells_y_q <= DIM_W'(1);
		end else if (psel && penable && pwrite && pready) begin
			unique case (ridx)
				REG_MIRROR:  mirror_q  <= pwdata[0];
				REG_CELLS_X: cells_x_q <= pwdata[DIM_W-1:0];
				REG_CELLS_Y: cells_y_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_MIRROR:  prdata = {31'd0, mirror_q};
			REG_CELLS_X: prdata = {{(32-DIM_W){1'b0}}, cells_x_q};
			REG_CELLS_Y: prdata = {{(32-DIM_W){1'b0}}, cells_y_q};
			default:     prdata = '0;
		endcase
	end

	assign nx = (cells_x_q == '0) ? DIM_W'(1) : cells_x_q;
	assign ny = (cells_y_q == '0) ? DIM_W'(1) : cells_y_q;

	logic                            vld  [NST+1];
	logic                            rdy  [NST+1];
	div_ctl_t                        ctl  [NST+1];
	logic [NUM_CORNERS*CORNER_W-1:0] corn [NST+1];
	div_ctl_t                        ctl_in [NST];

	assign vld[0] = s_tvalid;
	assign s_tready = rdy[0];
	assign ctl[0] = '{cidx: s_tdata[CELL_W-1:0], num: s_tdata[CELL_W-1:0],
		rem: '0, r1_odd: 1'b0};

	for (genvar i = 0; i < NUM_CORNERS; i++) begin : g_corn
		assign corn[0][i*CORNER_W +: CORNER_W] = s_tdata[(i+1)*CELL_W +: CORNER_W];
	end

	for (genvar i = 0; i < NST; i++) begin : g_div
		if (i == DIV_STAGES) begin : g_restart
			// second division: quotient by cells_y, keep X remainder parity
			assign ctl_in[i] = '{cidx: ctl[i].cidx, num: ctl[i].num, rem: '0,
				r1_odd: ctl[i].rem[0]};
		end else begin : g_pass
			assign ctl_in[i] = ctl[i];
		end
		tts_div_stage #(.CORNER_W(CORNER_W)) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.divisor   ((i < DIV_STAGES) ? nx : ny),
			.in_valid  (vld[i]),
			.in_ready  (rdy[i]),
			.in_ctl    (ctl_in[i]),
			.in_corn   (corn[i]),
			.out_valid (vld[i+1]),
			.out_ready (rdy[i+1]),
			.out_ctl   (ctl[i+1]),
			.out_corn  (corn[i+1])
		);
	end

	tts_emit #(.CORNER_W(CORNER_W)) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.mirror_en (mirror_q),
		.in_valid  (vld[NST]),
		.in_ready  (rdy[NST]),
		.in_ctl    (ctl[NST]),
		.in_corn   (corn[NST]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule
`default_nettype wire

/* src/tts_checker.sv */
// Port-level checks on the result stream of the splitter, bound to the top level.
// Depends on tts_pkg and hexa_to_six_tetra_split_top.
`default_nettype none
module tts_checker
	import tts_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [5*CELL_W-1:0] m_tdata,
	input wire logic                m_tlast
);

	logic [TET_CNT_W-1:0] beat_q;
	logic [CELL_W-1:0]    cell_q;
	logic                 xfer;

	assign xfer = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q <= '0;
		end else if (xfer) begin
			beat_q <= (beat_q == LAST_TET) ? '0 : beat_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			cell_q <= m_tdata[4*CELL_W +: CELL_W];
		end
	end

	a_last_sixth: assert property (@(posedge clk) disable iff (!arst_n)
		xfer |-> (m_tlast == (beat_q == LAST_TET)))
		else $error("tlast not on every sixth transaction");

	a_same_cell: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && beat_q != '0 |-> m_tdata[4*CELL_W +: CELL_W] == cell_q)
		else $error("source_cell changed within a cell");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("tvalid dropped under stall");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("payload changed under stall");

endmodule

bind hexa_to_six_tetra_split_top tts_checker u_tts_checker (.*);
`default_nettype wire
